// ----- sv/crs_pkg.sv -----
// crs_pkg: shared constants, codes and controller/datapath link types
// for the c-look request scheduler; no dependencies
package crs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SECTOR_BITS = 48;
    localparam int TAG_BITS        = 8;

    // operation codes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic scan_inc;
        logic exec;
    } t_crs_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic scan_done;
        logic scan_hit;
        logic out_free;
    } t_crs_stat;

endpackage

// ----- sv/crs_ctrl.sv -----
// crs_ctrl: sequencer for the c-look request scheduler
// depends on crs_pkg (command and status structs)
module crs_ctrl import crs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_crs_stat i_stat,
    output t_crs_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.is_remove ? S_SCAN : S_EXEC;
            end
            S_SCAN: begin
                if (i_stat.scan_done || i_stat.scan_hit) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/crs_datapath.sv -----
// crs_datapath: compare-and-shift slot row, head register and result register
// depends on crs_pkg (codes, command and status structs)
module crs_datapath import crs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_crs_cmd               i_cmd,
    output t_crs_stat              o_stat,
    input  logic [1:0]             i_operation,
    input  logic [SECTOR_BITS-1:0] i_sector,
    input  logic [TAG_BITS-1:0]    i_tag,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [SECTOR_BITS-1:0] o_out_sector,
    output logic [TAG_BITS-1:0]    o_out_tag,
    output logic [CW-1:0]          o_entries_held
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [SECTOR_BITS-1:0] r_sec [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    r_tag [QUEUE_DEPTH];
    logic [CW-1:0]          r_count;
    logic [SECTOR_BITS-1:0] r_head;
    logic [QUEUE_DEPTH-1:0] r_flag;
    logic [CW-1:0]          r_idx;

    logic [1:0]             r_op;
    logic [SECTOR_BITS-1:0] r_isec;
    logic [TAG_BITS-1:0]    r_itag;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [SECTOR_BITS-1:0] r_osec;
    logic [TAG_BITS-1:0]    r_otag;
    logic [CW-1:0]          r_oheld;

    logic [QUEUE_DEPTH-1:0] n_flag;
    logic [1:0]             n_status;
    logic [CW-1:0]          n_count;
    logic [QUEUE_DEPTH-1:0] w_prev;
    logic                   w_fresh_low;
    logic                   w_full;
    logic                   w_found;
    logic                   w_pop;

    // per-slot evaluation: c-look ordering for add, tag match for remove
    assign w_fresh_low = (r_isec < r_head);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CW'(i) >= r_count) begin
                n_flag[i] = 1'b0;
            end else if (r_op == OP_REMOVE) begin
                n_flag[i] = (r_tag[i] == r_itag);
            end else if (w_fresh_low) begin
                n_flag[i] = (r_sec[i] < r_head) && (r_isec < r_sec[i]);
            end else begin
                n_flag[i] = (r_sec[i] < r_head) || (r_isec < r_sec[i]);
            end
        end
    end

    assign w_prev  = {r_flag[QUEUE_DEPTH-2:0], 1'b0};
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_found = (r_idx < r_count);
    assign w_pop   = (r_op == OP_DISPATCH) && (r_count != '0);

    // status and entry count after the operation commits
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        case (r_op)
            OP_ADD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DISPATCH: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.is_remove = (r_op == OP_REMOVE);
    assign o_stat.scan_done = !w_found;
    assign o_stat.scan_hit  = w_found && r_flag[r_idx[PW-1:0]];
    assign o_stat.out_free  = !r_out_valid || i_ready;

    // slot row and request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_isec <= i_sector;
            r_itag <= i_tag;
        end
        if (i_cmd.eval) begin
            r_flag <= n_flag;
        end
        if (i_cmd.exec) begin
            case (r_op)
                OP_ADD: begin
                    if (!w_full) begin
                        // insert where the flags first turn on, or at the tail
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                            if (!w_prev[i] && (r_flag[i] || CW'(i) == r_count)) begin
                                r_sec[i] <= r_isec;
                                r_tag[i] <= r_itag;
                            end
                        end
                        // slots behind the insert point move back by one
                        for (int i = 1; i < QUEUE_DEPTH; i++) begin
                            if (w_prev[i]) begin
                                r_sec[i] <= r_sec[i-1];
                                r_tag[i] <= r_tag[i-1];
                            end
                        end
                    end
                end
                OP_DISPATCH: begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        r_sec[i] <= r_sec[i+1];
                        r_tag[i] <= r_tag[i+1];
                    end
                end
                OP_REMOVE: begin
                    if (w_found) begin
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            if (CW'(i) >= r_idx) begin
                                r_sec[i] <= r_sec[i+1];
                                r_tag[i] <= r_tag[i+1];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers, head and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_idx <= '0;
            end else if (i_cmd.scan_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                r_status <= n_status;
                r_count  <= n_count;
                r_oheld  <= n_count;
                if (w_pop) begin
                    r_osec <= r_sec[0];
                    r_otag <= r_tag[0];
                    r_head <= r_sec[0];
                end else begin
                    r_osec <= '0;
                    r_otag <= '0;
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_sector   = r_osec;
    assign o_out_tag      = r_otag;
    assign o_entries_held = r_oheld;

    // the queue never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // a dispatch from a non-empty queue moves the head to the popped sector
    a_head_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_DISPATCH && r_count != '0)
            |=> (r_head == $past(r_sec[0])))
        else $error("head not moved on dispatch");

    // the tag scan never runs past the queued entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_inc |-> (r_idx < r_count))
        else $error("tag scan past queue end");

endmodule

// ----- sv/clook_request_scheduler.sv -----
// clook_request_scheduler: c-look disk request queue, top level
// depends on crs_pkg, crs_ctrl and crs_datapath
//
// usage
//   input channel (i_valid / o_ready) carries one operation per transfer:
//   add a request (sector, tag), dispatch the front request, or remove a
//   request by tag. output channel (o_valid / i_ready) returns exactly one
//   result per operation: status, dispatched sector and tag (zero unless a
//   dispatch succeeded) and the number of entries held afterwards.
//   steps: an add, dispatch or unused code is captured, evaluated and then
//   committed to the output register that drives o_valid; a remove adds a
//   tag scan between evaluation and commit over the stored entries up to
//   and including the match, or over all of them when no tag matches.
//   one operation is taken at a time: o_ready stays low until the current
//   one commits. the slot row compares every entry in parallel in its
//   evaluate step and shifts them in its commit step.
//   the result sits in an output register, so a new operation is taken and
//   evaluated while the previous result waits; if the receiver stalls, the
//   block holds at its commit step until the result register frees.
//   reset (i_rst_n, synchronous, active low) empties the queue and puts the
//   head position at sector 0; slot contents are not cleared.
module clook_request_scheduler import crs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_operation,
    input  logic [SECTOR_BITS-1:0]             i_sector,
    input  logic [TAG_BITS-1:0]                i_tag,
    // output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [SECTOR_BITS-1:0]             o_out_sector,
    output logic [TAG_BITS-1:0]                o_out_tag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_entries_held
);

    // command and status link between sequencer and slot row
    t_crs_cmd  w_cmd;
    t_crs_stat w_stat;

    crs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // slot row holds the queue in service order; each slot compares itself
    // against the fresh request and the head, so insert point is found
    // locally from its neighbour's flag
    crs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_operation    (i_operation),
        .i_sector       (i_sector),
        .i_tag          (i_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_sector   (o_out_sector),
        .o_out_tag      (o_out_tag),
        .o_entries_held (o_entries_held)
    );

endmodule

// ----- tb/clook_request_scheduler_checker.sv -----
// clook_request_scheduler_checker: watches both channels of the c-look queue,
// keeps its own copy of the queue and compares every result in order
// depends on crs_pkg
`timescale 1ns / 1ps

module clook_request_scheduler_checker import crs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = DEF_SECTOR_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [1:0]                       i_operation,
    input  logic [SECTOR_BITS-1:0]           i_sector,
    input  logic [TAG_BITS-1:0]              i_tag,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_ready,
    input  logic [1:0]                       i_status,
    input  logic [SECTOR_BITS-1:0]           i_out_sector,
    input  logic [TAG_BITS-1:0]              i_out_tag,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_entries_held,
    output int                               o_failures,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_full_rejects,
    output int                               o_empty_dispatches,
    output int                               o_missed_removes
);

    localparam int HELD_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]             status;
        logic [SECTOR_BITS-1:0] sector;
        logic [TAG_BITS-1:0]    tag;
        logic [HELD_BITS-1:0]   held;
    } t_outcome;

    logic [SECTOR_BITS-1:0] slot_sector [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    slot_tag [QUEUE_DEPTH];
    int                     held_count;
    logic [SECTOR_BITS-1:0] head_sector;
    t_outcome               outcome_q [$];

    // c-look order: sectors at or above the head first, then the wrapped ones
    function automatic bit serves_ahead(input logic [SECTOR_BITS-1:0] fresh,
                                        input logic [SECTOR_BITS-1:0] queued);
        if (fresh < head_sector)
            return (queued < head_sector) && (fresh < queued);
        return (queued < head_sector) || (fresh < queued);
    endfunction

    function automatic void close_gap(input int pos);
        for (int k = pos; k + 1 < held_count; k++) begin
            slot_sector[k] = slot_sector[k+1];
            slot_tag[k]    = slot_tag[k+1];
        end
        held_count--;
    endfunction

    function automatic t_outcome queue_outcome(input logic [1:0]             op,
                                               input logic [SECTOR_BITS-1:0] sec,
                                               input logic [TAG_BITS-1:0]    tag);
        t_outcome res;
        int       pos;
        bit       found;
        res   = '0;
        found = 1'b0;
        case (op)
            OP_ADD: begin
                if (held_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = held_count;
                    for (int k = 0; k < held_count && !found; k++) begin
                        if (serves_ahead(sec, slot_sector[k])) begin
                            pos   = k;
                            found = 1'b1;
                        end
                    end
                    for (int k = held_count; k > pos; k--) begin
                        slot_sector[k] = slot_sector[k-1];
                        slot_tag[k]    = slot_tag[k-1];
                    end
                    slot_sector[pos] = sec;
                    slot_tag[pos]    = tag;
                    held_count++;
                end
            end
            OP_DISPATCH: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.sector  = slot_sector[0];
                    res.tag     = slot_tag[0];
                    head_sector = slot_sector[0];
                    close_gap(0);
                end
            end
            OP_REMOVE: begin
                // first match in service order goes
                res.status = ST_NOT_FOUND;
                for (int k = 0; k < held_count && !found; k++) begin
                    if (slot_tag[k] == tag) begin
                        close_gap(k);
                        res.status = ST_OK;
                        found      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.held = held_count[HELD_BITS-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            o_failures++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            held_count  = 0;
            head_sector = '0;
            outcome_q.delete();
            o_failures         = 0;
            o_pending          = 0;
            o_checked          = 0;
            o_full_rejects     = 0;
            o_empty_dispatches = 0;
            o_missed_removes   = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcome_q.size() == 0) begin
                    o_failures++;
                    $display("%0t: unexpected result, status %0d sector %h tag %h held %0d",
                             $time, i_status, i_out_sector, i_out_tag, i_entries_held);
                end else begin
                    want = outcome_q.pop_front();
                    o_checked++;
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("out_sector", 64'(want.sector), 64'(i_out_sector));
                    check_field("out_tag", 64'(want.tag), 64'(i_out_tag));
                    check_field("entries_held", 64'(want.held), 64'(i_entries_held));
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = queue_outcome(i_operation, i_sector, i_tag);
                outcome_q.push_back(want);
                if (want.status == ST_FULL)
                    o_full_rejects++;
                if (want.status == ST_EMPTY)
                    o_empty_dispatches++;
                if (want.status == ST_NOT_FOUND)
                    o_missed_removes++;
            end
            o_pending = outcome_q.size();
        end
    end

endmodule

// ----- tb/clook_request_scheduler_tb.sv -----
// clook_request_scheduler_tb: stimulus and verdict for the c-look request queue
// depends on crs_pkg, clook_request_scheduler and clook_request_scheduler_checker
`timescale 1ns / 1ps

module clook_request_scheduler_tb;
    import crs_pkg::*;

    localparam int HELD_BITS = $clog2(DEF_QUEUE_DEPTH + 1);
    // code the block treats as a no-op
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [DEF_SECTOR_BITS-1:0] SECTOR_TOP = {DEF_SECTOR_BITS{1'b1}};
    localparam int RANDOM_PER_PHASE = 600;

    // traffic mix for the random part
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_operation;
    logic [DEF_SECTOR_BITS-1:0] i_sector;
    logic [TAG_BITS-1:0]        i_tag;
    logic                       o_valid;
    logic                       i_ready;
    logic [1:0]                 o_status;
    logic [DEF_SECTOR_BITS-1:0] o_out_sector;
    logic [TAG_BITS-1:0]        o_out_tag;
    logic [HELD_BITS-1:0]       o_entries_held;

    int failures;
    int pending;
    int checked;
    int full_rejects;
    int empty_dispatches;
    int missed_removes;

    // percentage of cycles each side holds back
    int tx_idle_pct;
    int rx_idle_pct;

    clook_request_scheduler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_sector       (i_sector),
        .i_tag          (i_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_sector   (o_out_sector),
        .o_out_tag      (o_out_tag),
        .o_entries_held (o_entries_held)
    );

    clook_request_scheduler_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_operation        (i_operation),
        .i_sector           (i_sector),
        .i_tag              (i_tag),
        .i_rsp_valid        (o_valid),
        .i_rsp_ready        (i_ready),
        .i_status           (o_status),
        .i_out_sector       (o_out_sector),
        .i_out_tag          (o_out_tag),
        .i_entries_held     (o_entries_held),
        .o_failures         (failures),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_full_rejects     (full_rejects),
        .o_empty_dispatches (empty_dispatches),
        .o_missed_removes   (missed_removes)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // generous cap: a correct run needs well under a tenth of this
    initial begin
        #5_000_000;
        $display("clook_request_scheduler: mismatch");
        $finish;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // sectors: plenty of small ones so equal sectors and wrap-round around
    // the head turn up often, plus the two ends and full-width values
    function automatic logic [DEF_SECTOR_BITS-1:0] pick_sector();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(9))
            0:          return '0;
            1:          return SECTOR_TOP;
            2, 3, 4, 5: return DEF_SECTOR_BITS'($urandom_range(63));
            default:    return wide[DEF_SECTOR_BITS-1:0];
        endcase
    endfunction

    // narrow tag pool most of the time so removes hit and duplicates occur
    function automatic logic [TAG_BITS-1:0] pick_tag();
        if ($urandom_range(99) < 70)
            return TAG_BITS'($urandom_range(15));
        return TAG_BITS'($urandom_range(255));
    endfunction

    function automatic logic [1:0] pick_op(input int mix);
        int roll;
        int add_cut;
        int dispatch_cut;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin add_cut = 65; dispatch_cut = 80; end
            MIX_DRAIN: begin add_cut = 25; dispatch_cut = 75; end
            default:   begin add_cut = 40; dispatch_cut = 70; end
        endcase
        if (roll < add_cut)
            return OP_ADD;
        if (roll < dispatch_cut)
            return OP_DISPATCH;
        if (roll < 97)
            return OP_REMOVE;
        return OP_SPARE;
    endfunction

    // one transfer on the request channel; called on a falling edge and
    // returns on the falling edge after the transfer, so valid stays high
    // across back-to-back operations without a glitch
    task automatic issue(input logic [1:0] op, input logic [DEF_SECTOR_BITS-1:0] sec,
                         input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_sector    <= sec;
        i_tag       <= tag;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int mix;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_ADD;
        i_sector    = '0;
        i_tag       = '0;
        tx_idle_pct = 7;
        rx_idle_pct = 63;
        mix         = MIX_EVEN;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-queue cases and the unused code
        issue(OP_DISPATCH, '0, '0);
        issue(OP_REMOVE, '0, 8'd5);
        issue(OP_SPARE, SECTOR_TOP, 8'hff);
        // extremes of sector and tag, equal sectors kept in arrival order
        issue(OP_ADD, 48'd100, 8'd1);
        issue(OP_ADD, 48'd100, 8'd2);
        issue(OP_ADD, SECTOR_TOP, 8'hff);
        issue(OP_ADD, '0, 8'h00);
        // two dispatches move the head up to sector 100
        issue(OP_DISPATCH, '0, '0);
        issue(OP_DISPATCH, '0, '0);
        // sector below the head wraps to the back
        issue(OP_ADD, 48'd20, 8'd3);
        // duplicate tag added behind the first one in service order: the first is removed
        issue(OP_ADD, 48'd200, 8'd2);
        issue(OP_REMOVE, '0, 8'd2);
        issue(OP_REMOVE, '0, 8'd77);
        // fill up, then one add against a full queue
        repeat (14) issue(OP_ADD, pick_sector(), pick_tag());

        // random part in three pressure phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 7;  rx_idle_pct = 63; end
                1:       begin tx_idle_pct = 63; rx_idle_pct = 7;  end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // bursts of filling and draining push the queue to both ends
                if (n % 40 == 0)
                    mix = $urandom_range(2);
                issue(pick_op(mix), pick_sector(), pick_tag());
            end
        end
        i_valid <= 1'b0;

        // drain, then give any stray result time to show up
        wait (pending == 0);
        repeat (40) @(posedge i_clk);

        $display("%0d operations checked in order under three back-pressure mixes",
                 checked);
        $display("%0d full adds refused, %0d empty dispatches, %0d removes missed",
                 full_rejects, empty_dispatches, missed_removes);
        if (failures == 0)
            $display("clook_request_scheduler: match");
        else
            $display("clook_request_scheduler: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/crs_pkg.sv
sv/crs_ctrl.sv
sv/crs_datapath.sv
sv/clook_request_scheduler.sv
tb/clook_request_scheduler_checker.sv
tb/clook_request_scheduler_tb.sv
